FILE: hw/rtl/bfsp_pkg.sv
package bfsp_pkg;

  localparam int WGT_W  = 18;
  localparam int DIST_W = 24;
  localparam int VTX_W  = 5;
  localparam int CNT_W  = 6;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [4:0] RESULT_LAST_K = 5'd31;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CFG_VERTEX_COUNT   = 2'd0;
  localparam logic [1:0] CFG_SOURCE_VERTEX  = 2'd1;
  localparam logic [1:0] CFG_TARGET_VERTEX  = 2'd2;
  localparam logic [1:0] CFG_NO_EDGE_WEIGHT = 2'd3;

  // Broadcast to every cell for the row in flight.
  typedef struct packed {
    logic              seed;
    logic [DIST_W-1:0] du;
  } cell_ctl_t;

  // Item handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic [WGT_W-1:0] w;
  } tok_t;

endpackage

FILE: hw/rtl/bfsp_ram.sv
module bfsp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bfsp_cell.sv
module bfsp_cell import bfsp_pkg::*; #(
  parameter int VW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [VW-1:0]     row,
  input  tok_t              tok_in,
  input  logic [VW-1:0]     vidx_in,
  output tok_t              tok_out,
  output logic [VW-1:0]     vidx_out,
  output logic              chg,
  output logic [DIST_W-1:0] best_dist,
  output logic [VW-1:0]     pred
);

  localparam logic [VW-1:0] ME = VW'(IDX);

  logic              vld_r, vld_nxt;
  logic              chg_r, chg_nxt;
  logic [WGT_W-1:0]  w_r;
  logic [VW-1:0]     vidx_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [VW-1:0]     pred_r, pred_nxt;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand;
  logic              hit;

  // Saturating candidate through the broadcast row vertex.
  assign sum  = {1'b0, ctl.du} + {{(DIST_W+1-WGT_W){1'b0}}, tok_in.w};
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign hit  = tok_in.valid && (vidx_in == ME);

  always_comb begin
    vld_nxt  = tok_in.valid;
    chg_nxt  = 1'b0;
    dist_nxt = dist_r;
    pred_nxt = pred_r;
    if (hit) begin
      if (ctl.seed) begin
        dist_nxt = {{(DIST_W-WGT_W){1'b0}}, tok_in.w};
        pred_nxt = row;
      end else if (dist_r > cand) begin
        dist_nxt = cand;
        pred_nxt = row;
        chg_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      chg_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      chg_r <= chg_nxt;
    end
    w_r    <= tok_in.w;
    vidx_r <= vidx_in;
    dist_r <= dist_nxt;
    pred_r <= pred_nxt;
  end

  assign tok_out.valid = vld_r;
  assign tok_out.w     = w_r;
  assign vidx_out      = vidx_r;
  assign chg           = chg_r;
  assign best_dist     = dist_r;
  assign pred          = pred_r;

endmodule

FILE: hw/rtl/bellman_ford_shortest_path.sv
// Bellman-Ford shortest paths over an undirected graph held as an adjacency
// matrix in a RAM of MAX_VERTICES squared words. A clear item sweeps the whole
// RAM, one word a cycle; an add-edge item writes the edge word and then its
// mirror. A run item seeds the distances from the source's row and
// then relaxes the rows one after another: each row is read from the RAM one
// word a cycle and streamed down a chain of cells, one cell per vertex, each
// holding that vertex's best distance and predecessor. Each row takes N
// reads, then the last word runs down the whole chain, then a step picks up
// the next row's distance, which may just have changed. A run makes at most
// N-1 passes and then gives one path result per cycle while the receiver is
// ready. Results leave through an output register; a new item is taken only
// when the block is idle and that register is empty. Configuration writes
// are always ready.
module bellman_ford_shortest_path import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: from_vertex[4:0], to_vertex[9:5], edge_weight[27:10], zero fill
  input  logic [31:0] in_tdata,
  // in_tuser: command[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: distance[23:0], path_vertex[28:24], zero fill
  output logic [31:0] out_tdata,
  // out_tuser: found[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = 2 * VW;
  localparam logic [7:0] MAXV8 = 8'(MAX_VERTICES);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_ADD2   = 7'b0000100,
    ST_ROW    = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_NEXT   = 7'b0100000,
    ST_REPORT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  vc_r, vc_nxt;
  logic [VTX_W-1:0]  src_r, src_nxt;
  logic [VTX_W-1:0]  tgt_r, tgt_nxt;
  logic [WGT_W-1:0]  noe_r, noe_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [VW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     v_r, v_nxt;
  logic [CW-1:0]     pass_r, pass_nxt;
  logic              seed_r, seed_nxt;
  logic [DIST_W-1:0] du_r, du_nxt;
  logic              changed_r, changed_nxt;
  logic              iss_vld_r, iss_vld_nxt;
  logic [VW-1:0]     iss_v_r, iss_v_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [VW-1:0]     ea_r, ea_nxt;
  logic [VW-1:0]     eb_r, eb_nxt;
  logic [WGT_W-1:0]  ew_r, ew_nxt;
  logic [VW-1:0]     cur_r, cur_nxt;
  logic [4:0]        k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic              of_r, of_nxt;
  logic [DIST_W-1:0] od_r, od_nxt;
  logic [VTX_W-1:0]  op_r, op_nxt;
  logic              ol_r, ol_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WGT_W-1:0]  ram_wdata, ram_rdata;

  tok_t              tok   [MAX_VERTICES+1];
  logic [VW-1:0]     vidx  [MAX_VERTICES+1];
  logic [DIST_W-1:0] dist_w[MAX_VERTICES];
  logic [VW-1:0]     pred_w[MAX_VERTICES];
  logic [MAX_VERTICES-1:0] chg_w, vld_w;
  cell_ctl_t         ctl;

  logic [VTX_W-1:0]  in_from, in_to;
  logic [WGT_W-1:0]  in_wgt;
  logic [7:0]        from8, to8, src8, tgt8, vc8, nsat8, n8, row8, pass8, cur8;
  logic              busy, unreach, fin;
  logic [VW-1:0]     row_inc;

  assign in_from = in_tdata[4:0];
  assign in_to   = in_tdata[9:5];
  assign in_wgt  = in_tdata[27:10];
  assign from8   = {3'b000, in_from};
  assign to8     = {3'b000, in_to};
  assign src8    = {3'b000, src_r};
  assign tgt8    = {3'b000, tgt_r};
  assign vc8     = {2'b00, vc_r};
  assign n8      = 8'(n_r);
  assign row8    = 8'(row_r);
  assign pass8   = 8'(pass_r);
  assign cur8    = 8'(cur_r);
  assign row_inc = row_r + 1'b1;

  // Vertex count clamped into the supported range.
  assign nsat8 = (vc8 < 8'd2) ? 8'd2 : ((vc8 > MAXV8) ? MAXV8 : vc8);

  assign in_tready = (state_r == ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;

  // The matrix RAM: row-major, address {row, column}.
  bfsp_ram #(
    .WIDTH (WGT_W),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = {row_r, v_r[VW-1:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = noe_r;
    case (state_r)
      ST_IDLE: begin
        ram_we    = in_tvalid && in_tready && (in_tuser == CMD_ADD) &&
                    (from8 < MAXV8) && (to8 < MAXV8);
        ram_waddr = {from8[VW-1:0], to8[VW-1:0]};
        ram_wdata = in_wgt;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r[AW-1:VW] == clr_r[VW-1:0]) ? '0 : noe_r;
      end
      ST_ADD2: begin
        ram_we    = 1'b1;
        ram_waddr = {eb_r, ea_r};
        ram_wdata = ew_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // The chain: a word read for column v enters cell 0 in the cycle after its
  // read and is acted on by cell v on its way down.
  assign ctl.seed     = seed_r;
  assign ctl.du       = du_r;
  assign tok[0].valid = iss_vld_r;
  assign tok[0].w     = ram_rdata;
  assign vidx[0]      = iss_v_r;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    bfsp_cell #(
      .VW  (VW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .row       (row_r),
      .tok_in    (tok[i]),
      .vidx_in   (vidx[i]),
      .tok_out   (tok[i+1]),
      .vidx_out  (vidx[i+1]),
      .chg       (chg_w[i]),
      .best_dist (dist_w[i]),
      .pred      (pred_w[i])
    );
    assign vld_w[i] = tok[i+1].valid;
  end

  assign busy = iss_vld_r || (|vld_w);

  // Path walk: the target is unreachable when its distance is the marker.
  assign unreach = (dist_w[tgt8[VW-1:0]] == {{(DIST_W-WGT_W){1'b0}}, noe_r});
  assign fin     = unreach || (cur8 == src8) || (k_r == RESULT_LAST_K);

  always_comb begin
    state_nxt   = state_r;
    vc_nxt      = vc_r;
    src_nxt     = src_r;
    tgt_nxt     = tgt_r;
    noe_nxt     = noe_r;
    n_nxt       = n_r;
    row_nxt     = row_r;
    v_nxt       = v_r;
    pass_nxt    = pass_r;
    seed_nxt    = seed_r;
    du_nxt      = du_r;
    changed_nxt = changed_r | (|chg_w);
    iss_vld_nxt = 1'b0;
    iss_v_nxt   = v_r[VW-1:0];
    clr_nxt     = clr_r;
    ea_nxt      = ea_r;
    eb_nxt      = eb_r;
    ew_nxt      = ew_r;
    cur_nxt     = cur_r;
    k_nxt       = k_r;
    ov_nxt      = ov_r && !out_tready;
    of_nxt      = of_r;
    od_nxt      = od_r;
    op_nxt      = op_r;
    ol_nxt      = ol_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:   vc_nxt  = cfg_data[CNT_W-1:0];
        CFG_SOURCE_VERTEX:  src_nxt = cfg_data[VTX_W-1:0];
        CFG_TARGET_VERTEX:  tgt_nxt = cfg_data[VTX_W-1:0];
        CFG_NO_EDGE_WEIGHT: noe_nxt = cfg_data;
        default:            vc_nxt  = vc_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (in_tuser)
            CMD_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_ADD: begin
              if ((from8 < MAXV8) && (to8 < MAXV8)) begin
                ea_nxt    = from8[VW-1:0];
                eb_nxt    = to8[VW-1:0];
                ew_nxt    = in_wgt;
                state_nxt = ST_ADD2;
              end
            end
            CMD_RUN: begin
              n_nxt = nsat8[CW-1:0];
              if ((src8 >= nsat8) || (tgt8 >= nsat8)) begin
                ov_nxt = 1'b1;
                of_nxt = 1'b0;
                od_nxt = {{(DIST_W-WGT_W){1'b0}}, noe_r};
                op_nxt = tgt_r;
                ol_nxt = 1'b1;
              end else begin
                row_nxt   = src8[VW-1:0];
                seed_nxt  = 1'b1;
                du_nxt    = '0;
                v_nxt     = '0;
                state_nxt = ST_ROW;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD2: begin
        state_nxt = ST_IDLE;
      end
      ST_ROW: begin
        iss_vld_nxt = 1'b1;
        iss_v_nxt   = v_r[VW-1:0];
        v_nxt       = v_r + 1'b1;
        if (8'(v_r) + 8'd1 >= n8) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        v_nxt = '0;
        if (seed_r) begin
          seed_nxt    = 1'b0;
          pass_nxt    = '0;
          row_nxt     = '0;
          du_nxt      = dist_w[0];
          changed_nxt = 1'b0;
          state_nxt   = ST_ROW;
        end else if (row8 + 8'd1 < n8) begin
          row_nxt   = row_inc;
          du_nxt    = dist_w[row_inc];
          state_nxt = ST_ROW;
        end else if (changed_r && (pass8 + 8'd2 < n8)) begin
          pass_nxt    = pass_r + 1'b1;
          row_nxt     = '0;
          du_nxt      = dist_w[0];
          changed_nxt = 1'b0;
          state_nxt   = ST_ROW;
        end else begin
          cur_nxt   = tgt8[VW-1:0];
          k_nxt     = '0;
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!ov_r || out_tready) begin
          ov_nxt  = 1'b1;
          of_nxt  = !unreach;
          od_nxt  = dist_w[tgt8[VW-1:0]];
          op_nxt  = cur8[VTX_W-1:0];
          ol_nxt  = fin;
          cur_nxt = pred_w[cur_r];
          k_nxt   = k_r + 1'b1;
          if (fin) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vc_r      <= 6'd32;
      src_r     <= '0;
      tgt_r     <= '0;
      noe_r     <= 18'd160000;
      seed_r    <= 1'b0;
      changed_r <= 1'b0;
      iss_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vc_r      <= vc_nxt;
      src_r     <= src_nxt;
      tgt_r     <= tgt_nxt;
      noe_r     <= noe_nxt;
      seed_r    <= seed_nxt;
      changed_r <= changed_nxt;
      iss_vld_r <= iss_vld_nxt;
      ov_r      <= ov_nxt;
    end
    n_r    <= n_nxt;
    row_r  <= row_nxt;
    v_r    <= v_nxt;
    pass_r <= pass_nxt;
    du_r   <= du_nxt;
    iss_v_r <= iss_v_nxt;
    clr_r  <= clr_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    ew_r   <= ew_nxt;
    cur_r  <= cur_nxt;
    k_r    <= k_nxt;
    of_r   <= of_nxt;
    od_r   <= od_nxt;
    op_r   <= op_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = of_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {3'b000, op_r, od_r};

endmodule

FILE: test/bfsp_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the shortest path block, keeps its own copy
// of the graph and the registers, predicts the result items of every run and
// compares them in order with what leaves the block.
module bfsp_checker import bfsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NV = 32;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] dval;
    logic [VTX_W-1:0]  vtx;
    logic              last;
  } path_step_t;

  logic [CNT_W-1:0]  vcount;
  logic [VTX_W-1:0]  src, tgt;
  logic [WGT_W-1:0]  nedge;
  logic [WGT_W-1:0]  adj [NV][NV];
  path_step_t        path_q [$];

  assign pending = path_q.size();

  task automatic report(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Relaxation over the matrix, then the predecessor walk from the target.
  task automatic predict_path();
    logic [DIST_W-1:0] best [NV];
    logic [VTX_W-1:0]  pred [NV];
    logic [DIST_W:0]   cand;
    logic [VTX_W-1:0]  cur;
    int n, k;
    bit changed, fin;
    n = vcount;
    if (n < 2) n = 2;
    if (n > NV) n = NV;
    if (src >= n || tgt >= n) begin
      path_q.push_back('{1'b0, DIST_W'(nedge), tgt, 1'b1});
      return;
    end
    for (int v = 0; v < n; v++) begin
      best[v] = DIST_W'(adj[src][v]);
      pred[v] = src;
    end
    for (int p = 0; p + 1 < n; p++) begin
      changed = 0;
      for (int u = 0; u < n; u++) begin
        for (int v = 0; v < n; v++) begin
          cand = best[u] + adj[u][v];
          if (cand > DIST_MAX) cand = DIST_MAX;
          if (best[v] > cand[DIST_W-1:0]) begin
            best[v] = cand[DIST_W-1:0];
            pred[v] = VTX_W'(u);
            changed = 1;
          end
        end
      end
      if (!changed) break;
    end
    if (best[tgt] == DIST_W'(nedge)) begin
      path_q.push_back('{1'b0, best[tgt], tgt, 1'b1});
      return;
    end
    cur = tgt;
    for (k = 0; k < 32; k++) begin
      fin = (cur == src) || (k == 31);
      path_q.push_back('{1'b1, best[tgt], cur, fin});
      if (fin) break;
      cur = pred[cur];
    end
  endtask

  always @(posedge clk) begin
    path_step_t want;
    logic [VTX_W-1:0] a, b;
    if (!rst_n) begin
      vcount = 6'd32;
      src = '0;
      tgt = '0;
      nedge = 18'd160000;
      path_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERTEX_COUNT:   vcount = cfg_data[CNT_W-1:0];
          CFG_SOURCE_VERTEX:  src = cfg_data[VTX_W-1:0];
          CFG_TARGET_VERTEX:  tgt = cfg_data[VTX_W-1:0];
          CFG_NO_EDGE_WEIGHT: nedge = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        a = in_tdata[4:0];
        b = in_tdata[9:5];
        case (in_tuser)
          CMD_CLEAR: begin
            for (int u = 0; u < NV; u++)
              for (int v = 0; v < NV; v++)
                adj[u][v] = (u == v) ? '0 : nedge;
          end
          CMD_ADD: begin
            adj[a][b] = in_tdata[27:10];
            adj[b][a] = in_tdata[27:10];
          end
          CMD_RUN: predict_path();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (path_q.size() == 0) begin
          report($sformatf("unexpected result item dist=%0d vtx=%0d",
                           out_tdata[23:0], out_tdata[28:24]));
        end else begin
          want = path_q.pop_front();
          if (out_tuser !== want.found)
            report($sformatf("found %b, want %b", out_tuser, want.found));
          if (out_tdata[23:0] !== want.dval)
            report($sformatf("distance %0d, want %0d", out_tdata[23:0], want.dval));
          if (out_tdata[28:24] !== want.vtx)
            report($sformatf("path vertex %0d, want %0d", out_tdata[28:24], want.vtx));
          if (out_tlast !== want.last)
            report($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the shortest path block. The checker beside the
// block does all prediction and comparison; this module only drives items,
// register writes and backpressure, and decides pass or fail at the end.
module tb import bfsp_pkg::*;;

  localparam int LIMIT = 10000000;
  // A clear sweeps the whole matrix with no result, so register writes wait
  // this long after the last result of a phase.
  localparam int SETTLE = 1200;

  logic        clk = 0;
  logic        rst_n = 0;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tuser, out_tlast, out_tvalid;
  logic        out_tready = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int runs_sent = 0;
  int items_sent = 0;
  // While set, neither side idles.
  bit steady = 0;
  int n_cur;

  always #5 clk = ~clk;

  bellman_ford_shortest_path DUT (.*);

  bfsp_checker chk (.*);

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls with a chance of roughly one in nine, except while steady.
  always @(negedge clk) begin
    out_tready = steady || ($urandom_range(99) >= 11);
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [17:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_graph_regs(input int n, input int s, input int t, input int ne);
    cfg_write(CFG_VERTEX_COUNT, 18'(n));
    cfg_write(CFG_SOURCE_VERTEX, 18'(s));
    cfg_write(CFG_TARGET_VERTEX, 18'(t));
    cfg_write(CFG_NO_EDGE_WEIGHT, 18'(ne));
  endtask

  // Sends one item; valid stays high afterward unless a gap comes next.
  task automatic push_item(input logic [1:0] cmd, input int a, input int b,
                           input logic [17:0] w);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 11) begin
      in_tvalid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tuser = cmd;
    in_tdata = {4'b0, w, 5'(b), 5'(a)};
    in_tvalid = 1;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_RUN) runs_sent++;
  endtask

  // Lowers valid and waits until every predicted result has left, then lets
  // any trailing clear finish before registers may change.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly small graph sizes keep runs short; a few go to the full size.
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 32;
    if (r < 12) return $urandom_range(1) ? 0 : 63;
    return $urandom_range(9, 2);
  endfunction

  function automatic logic [17:0] pick_weight(input int ne);
    case ($urandom_range(9))
      0: return '0;
      1: return 18'h3FFFF;
      2: return 18'(ne);
      3, 4: return 18'($urandom);
      default: return 18'($urandom_range(400));
    endcase
  endfunction

  initial begin
    int ne, s, t, edges;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: a four-vertex line with the weight extremes on it.
    steady = 1;
    set_graph_regs(4, 0, 3, 160000);
    push_item(CMD_CLEAR, 0, 0, '0);
    push_item(CMD_RUN, 0, 0, '0);          // target unreachable
    push_item(CMD_ADD, 0, 1, '0);
    push_item(CMD_ADD, 2, 1, 18'h3FFFF);
    push_item(CMD_ADD, 2, 3, 18'd16);
    push_item(CMD_ADD, 2, 2, 18'd5);       // self edge rewrites the diagonal
    push_item(CMD_ADD, 31, 30, 18'd1);     // beyond the graph size, stored only
    push_item(CMD_UNUSED, 31, 31, 18'h3FFFF); // unused command is ignored
    push_item(CMD_RUN, 0, 0, '0);
    push_item(CMD_ADD, 0, 3, 18'd7);       // shortcut replaces the long path
    push_item(CMD_RUN, 0, 0, '0);
    drain();
    steady = 0;

    // Target equal to source, then source beyond the graph.
    cfg_write(CFG_TARGET_VERTEX, 18'd0);
    push_item(CMD_RUN, 0, 0, '0);
    drain();
    set_graph_regs(4, 9, 2, 160000);
    push_item(CMD_RUN, 0, 0, '0);
    drain();

    // No-edge weight at both extremes; the clear takes the value held now.
    set_graph_regs(3, 0, 2, 0);
    push_item(CMD_CLEAR, 0, 0, '0);
    push_item(CMD_ADD, 0, 1, 18'd3);
    push_item(CMD_RUN, 0, 0, '0);
    drain();
    set_graph_regs(3, 2, 0, 18'h3FFFF);
    push_item(CMD_RUN, 0, 0, '0);
    push_item(CMD_CLEAR, 0, 0, '0);
    push_item(CMD_ADD, 1, 2, 18'h3FFFF);
    push_item(CMD_RUN, 0, 0, '0);
    drain();

    // Full-size chain: a path through all 32 vertices fills the result cap.
    steady = 1;
    set_graph_regs(32, 0, 31, 18'h3FFFF);
    push_item(CMD_CLEAR, 0, 0, '0);
    for (int v = 0; v < 31; v++) push_item(CMD_ADD, v, v + 1, 18'($urandom_range(300, 1)));
    push_item(CMD_RUN, 0, 0, '0);
    drain();
    steady = 0;

    // Random graphs: clear, a burst of edges, then one or two runs.
    for (int ph = 0; items_sent < 100 || ph < 6; ph++) begin
      steady = (ph >= 3 && ph < 5);
      n_cur = pick_size();
      ne = ($urandom_range(5) == 0) ? int'(18'($urandom)) : 160000;
      s = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1);
      t = ($urandom_range(9) == 0) ? $urandom_range(31)
                                   : $urandom_range((n_cur >= 2 && n_cur <= 32) ? n_cur - 1 : 1);
      set_graph_regs(n_cur, s, t, ne);
      push_item(CMD_CLEAR, 0, 0, '0);
      edges = $urandom_range(12, 1);
      for (int e = 0; e < edges; e++) begin
        if ($urandom_range(19) == 0)
          push_item($urandom_range(1) ? CMD_UNUSED : CMD_ADD, $urandom_range(31),
                    $urandom_range(31), 18'($urandom));
        else
          push_item(CMD_ADD, $urandom_range(n_cur > 2 && n_cur <= 32 ? n_cur - 1 : 1),
                    $urandom_range(n_cur > 2 && n_cur <= 32 ? n_cur - 1 : 1),
                    pick_weight(ne));
      end
      push_item(CMD_RUN, 0, 0, '0);
      if ($urandom_range(2) == 0) begin
        push_item(CMD_ADD, $urandom_range(1), $urandom_range(3), pick_weight(ne));
        push_item(CMD_RUN, 0, 0, '0);
      end
      drain();
    end
    steady = 0;

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
